FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tplc_pkg.sv
package tplc_pkg;

    localparam int FW = 10;
    localparam int CW = 16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_NOBUILD = 2'd2;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_B1,
        S_B2,
        S_B3,
        S_D1,
        S_D2,
        S_D3,
        S_EQ,
        S_EQW,
        S_CMP,
        S_LA,
        S_LB,
        S_LC,
        S_P,
        S_PW,
        S_WRD,
        S_WWR,
        S_OUT
    } t_state;

endpackage

FILE: rtl/tplc_ifs.sv
interface tplc_in_if;
    import tplc_pkg::*;
    logic          valid;
    logic          ready;
    logic [1:0]    operation;
    logic [FW-1:0] node;
    logic [FW-1:0] other_node;
    logic [FW-1:0] parent_node;
    logic [FW-1:0] node_level;

    modport source (output valid, output operation, output node, output other_node,
                    output parent_node, output node_level, input ready);
    modport sink (input valid, input operation, input node, input other_node,
                  input parent_node, input node_level, output ready);
endinterface

interface tplc_out_if;
    import tplc_pkg::*;
    logic          valid;
    logic          ready;
    logic [FW-1:0] common_ancestor;
    logic [CW-1:0] busiest_count;
    logic [1:0]    status;

    modport source (output valid, output common_ancestor, output busiest_count,
                    output status, input ready);
    modport sink (input valid, input common_ancestor, input busiest_count,
                  input status, output ready);
endinterface

FILE: rtl/tree_path_lca_counter.sv
// Load, bad item, operation 3: the item passes through S_OUT to the result register.
// Build: each table entry passes through S_B1, S_B2 and S_B3, for levels 1 to LIFT_LEVELS-1.
// Query: the depth, lift and path walk steps run one after another, as the
// ancestor and count memories each have a single read port.
// One item at a time; the next item is taken while a result waits.
// Reset: synchronous; a clearing pass over all MAX_NODES entries zeroes the counts.
`include "assert_macros.svh"

module tree_path_lca_counter import tplc_pkg::*; #(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tplc_in_if.sink     i_in,
    tplc_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int LW = $clog2(LIFT_LEVELS);
    localparam int SW = AW + 1;
    localparam int TD = MAX_NODES * (2 ** LW);

    function automatic logic [FW-1:0] up_sel(logic [FW-1:0] nd, logic [FW-1:0] rd);
        return (nd == '0) ? '0 : rd;
    endfunction

    logic [FW-1:0] r_tmem [TD];
    logic [FW-1:0] r_dmem [MAX_NODES];
    logic [CW-1:0] r_cmem [MAX_NODES];
    logic [FW-1:0] r_trd, r_drd;
    logic [CW-1:0] r_crd;

    logic             t_we, d_we, c_we;
    logic [AW+LW-1:0] t_wa, t_ra;
    logic [FW-1:0]    t_wd, d_wd;
    logic [AW-1:0]    d_wa, d_ra, c_wa, c_ra;
    logic [CW-1:0]    c_wd;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [FW-1:0] r_ncount;
    logic          r_built, n_built;
    logic [CW-1:0] r_max, n_max;
    logic [FW-1:0] r_n, n_n, r_m, n_m, r_u, n_u, r_v, n_v;
    logic [FW-1:0] r_du, n_du, r_diff, n_diff, r_a, n_a, r_anc, n_anc, r_from, n_from;
    logic [LW-1:0] r_i, n_i, r_k, n_k;
    logic [AW-1:0] r_x, n_x;
    logic [SW-1:0] r_steps, n_steps;
    logic          r_pass, n_pass, r_final, n_final;
    logic [1:0]    r_stat, n_stat;
    logic          r_ovalid, n_ovalid;
    logic [FW-1:0] r_oanc, n_oanc;
    logic [1:0]    r_ostat, n_ostat;
    logic [CW-1:0] r_obusy, n_obusy;

    logic          v_n, v_m, v_p, x_last;
    logic [FW-1:0] b_val;
    logic [CW-1:0] cnt;
    logic [LW-1:0] km1;

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[t_wa] <= t_wd;
        end
        r_trd <= r_tmem[t_ra];
        if (d_we) begin
            r_dmem[d_wa] <= d_wd;
        end
        r_drd <= r_dmem[d_ra];
        if (c_we) begin
            r_cmem[c_wa] <= c_wd;
        end
        r_crd <= r_cmem[c_ra];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_NODE_COUNT) ? {{(32-FW){1'b0}}, r_ncount} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncount <= FW'(1);
        end else if (psel && penable && pwrite) begin
            r_ncount <= pwdata[FW-1:0];
        end
    end

    assign v_n = (i_in.node != '0) && (i_in.node <= r_ncount) && (32'(i_in.node) < MAX_NODES);
    assign v_m = (i_in.other_node != '0) && (i_in.other_node <= r_ncount)
                 && (32'(i_in.other_node) < MAX_NODES);
    assign v_p = (i_in.parent_node <= r_ncount) && (32'(i_in.parent_node) < MAX_NODES);
    assign x_last = (32'(r_x) == 32'(r_ncount)) || (32'(r_x) == MAX_NODES - 1);
    assign km1 = r_k - LW'(1);
    assign cnt = (r_crd == '1) ? r_crd : r_crd + CW'(1);

    assign i_in.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.common_ancestor = r_oanc;
    assign o_res.status = r_ostat;
    assign o_res.busiest_count = r_obusy;

    always_comb begin
        n_state = r_state;  n_clr = r_clr;    n_built = r_built;  n_max = r_max;
        n_n = r_n;          n_m = r_m;        n_u = r_u;          n_v = r_v;
        n_du = r_du;        n_diff = r_diff;  n_a = r_a;          n_anc = r_anc;
        n_from = r_from;    n_i = r_i;        n_k = r_k;          n_x = r_x;
        n_steps = r_steps;  n_pass = r_pass;  n_final = r_final;  n_stat = r_stat;
        n_ovalid = r_ovalid && !o_res.ready;
        n_oanc = r_oanc;    n_ostat = r_ostat; n_obusy = r_obusy;
        t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
        d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
        c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
        b_val = up_sel(r_v, r_trd);
        unique case (r_state)
            S_CLR: begin
                c_we = 1'b1;
                c_wa = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_stat = ST_OK;
                    n_anc = '0;
                    n_n = i_in.node;
                    n_m = i_in.other_node;
                    n_u = i_in.node;
                    n_v = i_in.other_node;
                    n_state = S_OUT;
                    unique case (i_in.operation)
                        OP_LOAD: begin
                            if (v_n && v_p) begin
                                t_we = 1'b1;
                                t_wa = {AW'(i_in.node), LW'(0)};
                                t_wd = i_in.parent_node;
                                d_we = 1'b1;
                                d_wa = AW'(i_in.node);
                                d_wd = i_in.node_level;
                                n_built = 1'b0;
                            end else begin
                                n_stat = ST_RANGE;
                            end
                        end
                        OP_BUILD: begin
                            n_k = LW'(1);
                            n_x = AW'(1);
                            if (r_ncount == '0) begin
                                n_built = 1'b1;
                            end else begin
                                n_state = S_B1;
                            end
                        end
                        OP_QUERY: begin
                            if (!v_n || !v_m) begin
                                n_stat = ST_RANGE;
                            end else if (!r_built) begin
                                n_stat = ST_NOBUILD;
                            end else begin
                                n_state = S_D1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_B1: begin
                t_ra = {r_x, km1};
                n_state = S_B2;
            end
            S_B2: begin
                n_a = r_trd;
                t_ra = {AW'(r_trd), km1};
                n_state = S_B3;
            end
            S_B3: begin
                t_we = 1'b1;
                t_wa = {r_x, r_k};
                t_wd = up_sel(r_a, r_trd);
                n_state = S_B1;
                if (x_last) begin
                    n_x = AW'(1);
                    if (r_k == LW'(LIFT_LEVELS - 1)) begin
                        n_built = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_k = r_k + LW'(1);
                    end
                end else begin
                    n_x = r_x + AW'(1);
                end
            end
            S_D1: begin
                d_ra = AW'(r_u);
                n_state = S_D2;
            end
            S_D2: begin
                n_du = r_drd;
                d_ra = AW'(r_v);
                n_state = S_D3;
            end
            S_D3: begin
                if (r_drd < r_du) begin
                    n_u = r_v;
                    n_v = r_u;
                    n_diff = r_du - r_drd;
                end else begin
                    n_diff = r_drd - r_du;
                end
                n_i = '0;
                n_state = S_EQ;
            end
            S_EQ: begin
                if (r_diff[0]) begin
                    t_ra = {AW'(r_v), r_i};
                    n_state = S_EQW;
                end else begin
                    n_diff = r_diff >> 1;
                    if (r_i == LW'(LIFT_LEVELS - 1)) begin
                        n_state = S_CMP;
                    end else begin
                        n_i = r_i + LW'(1);
                    end
                end
            end
            S_EQW: begin
                n_v = b_val;
                n_diff = r_diff >> 1;
                if (r_i == LW'(LIFT_LEVELS - 1)) begin
                    n_state = S_CMP;
                end else begin
                    n_i = r_i + LW'(1);
                    n_state = S_EQ;
                end
            end
            S_CMP: begin
                if (r_u == r_v) begin
                    n_anc = r_u;
                    n_from = r_n;
                    n_steps = '0;
                    n_pass = 1'b0;
                    n_final = 1'b0;
                    n_state = S_WRD;
                end else begin
                    n_i = LW'(LIFT_LEVELS - 1);
                    n_state = S_LA;
                end
            end
            S_LA: begin
                t_ra = {AW'(r_u), r_i};
                n_state = S_LB;
            end
            S_LB: begin
                n_a = up_sel(r_u, r_trd);
                t_ra = {AW'(r_v), r_i};
                n_state = S_LC;
            end
            S_LC: begin
                if (r_a != b_val) begin
                    n_u = r_a;
                    n_v = b_val;
                end
                if (r_i == '0) begin
                    n_state = S_P;
                end else begin
                    n_i = r_i - LW'(1);
                    n_state = S_LA;
                end
            end
            S_P: begin
                t_ra = {AW'(r_u), LW'(0)};
                n_state = S_PW;
            end
            S_PW: begin
                n_anc = up_sel(r_u, r_trd);
                n_from = r_n;
                n_steps = '0;
                n_pass = 1'b0;
                n_final = 1'b0;
                n_state = S_WRD;
            end
            S_WRD: begin
                if (r_final || (r_from != r_anc && r_steps != SW'(MAX_NODES))) begin
                    c_ra = AW'(r_from);
                    t_ra = {AW'(r_from), LW'(0)};
                    n_state = S_WWR;
                end else if (!r_pass) begin
                    n_from = r_m;
                    n_steps = '0;
                    n_pass = 1'b1;
                end else begin
                    n_from = r_anc;
                    n_final = 1'b1;
                end
            end
            S_WWR: begin
                c_we = 1'b1;
                c_wa = AW'(r_from);
                c_wd = cnt;
                if (cnt > r_max) begin
                    n_max = cnt;
                end
                if (r_final) begin
                    n_state = S_OUT;
                end else begin
                    n_from = up_sel(r_from, r_trd);
                    n_steps = r_steps + SW'(1);
                    n_state = S_WRD;
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_oanc = r_anc;
                    n_ostat = r_stat;
                    n_obusy = r_max;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_built <= 1'b0;
            r_max <= '0;
            r_steps <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_built <= n_built;
            r_max <= n_max;
            r_steps <= n_steps;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;       r_m <= n_m;         r_u <= n_u;       r_v <= n_v;
        r_du <= n_du;     r_diff <= n_diff;   r_a <= n_a;       r_anc <= n_anc;
        r_from <= n_from; r_i <= n_i;         r_k <= n_k;       r_x <= n_x;
        r_pass <= n_pass; r_final <= n_final; r_stat <= n_stat;
        r_oanc <= n_oanc; r_ostat <= n_ostat; r_obusy <= n_obusy;
    end

    `ASSERT_IMP(a_bld_lvl, t_we && r_state == S_B3, t_wa[LW-1:0] != '0, "build wrote level 0")
    `ASSERT_IMP(a_steps, 1'b1, r_steps <= SW'(MAX_NODES), "walk step count overrun")
    `ASSERT_IMP(a_err_anc, r_ovalid && r_ostat != ST_OK, r_oanc == '0, "error item with ancestor")
    `ASSERT_NXT(a_accept, i_in.valid && i_in.ready, r_state != S_IDLE, "accepted item lost")

endmodule
